>>> sv/hkit_pkg.sv
package hkit_pkg;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_POOL_EMPTY = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_t;

  localparam int COUNT_W = 11;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] hash;
    logic [31:0] key_high;
    logic [63:0] key_middle;
    logic [63:0] key_low;
    logic [31:0] segment_id;
    logic [31:0] segment_offset;
    logic [31:0] expiry_time;
    logic [63:0] cas_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_segment;
    logic [31:0] found_offset;
    logic [31:0] found_expiry;
    logic [63:0] found_cas;
    logic [10:0] free_count;
    logic [10:0] used_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key_high;
    logic [63:0] key_middle;
    logic [63:0] key_low;
    logic [31:0] segment;
    logic [31:0] offset;
    logic [31:0] expiry;
    logic [63:0] cas;
  } entry_t;

endpackage

>>> sv/hashed_key_index_table.sv
// Channel   Direction  Payload           Handshake
// in_       input      hkit_pkg::req_t   in_valid / in_stall
// out_      output     hkit_pkg::rsp_t   out_valid / out_stall
// cfg_      input      cfg_wr_data[3:0]  cfg_wr_en
// One request at a time. From the idle state, a lookup reads the bucket
// head, then each chain link; each link costs a read of the entry and link
// memories and one 160-bit key compare. An insert adds the S_FREE state and
// a remove that hits adds S_FIX and S_FREE. After reset a clearing pass
// over addresses 0 to max(2^MAX_HASH_POWER, ENTRY_COUNT)-1 empties the
// bucket heads and builds the free chain; one request may be accepted
// meanwhile and waits in the holding register.
// A waiting result does not block input acceptance into the holding register.
module hashed_key_index_table #(
  parameter int MAX_HASH_POWER = 10,
  parameter int ENTRY_COUNT    = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  hkit_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output hkit_pkg::rsp_t  out_data,
  input  logic            cfg_wr_en,
  input  logic [3:0]      cfg_wr_data
);
  import hkit_pkg::*;

  localparam int BUCKETS = 1 << MAX_HASH_POWER;
  localparam int BW = MAX_HASH_POWER;
  localparam int EW = $clog2(ENTRY_COUNT);
  localparam int PW = EW + 1;
  localparam int CLR = (BUCKETS > ENTRY_COUNT) ? BUCKETS : ENTRY_COUNT;
  localparam int CW = $clog2(CLR) + 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRY_COUNT);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_HEAD   = 9'b000000100,
    S_HWAIT  = 9'b000001000,
    S_EREAD  = 9'b000010000,
    S_EWAIT  = 9'b000100000,
    S_CHECK  = 9'b001000000,
    S_FIX    = 9'b010000000,
    S_FREE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0]    hp_r;
  logic [CW-1:0] clr_r;
  req_t          req_r;
  logic          req_v_r;
  rsp_t          rsp_r;
  logic          rsp_v_r;
  logic [BW-1:0] bkt_r;
  logic [PW-1:0] cur_r, prev_r;
  logic [EW:0]   steps_r;
  logic [PW-1:0] free_head_r;
  logic [COUNT_W-1:0] free_tot_r, used_tot_r;

  logic          bh_we;
  logic [BW-1:0] bh_wa, bh_ra;
  logic [PW-1:0] bh_wd, bh_rd;
  logic          nl_we;
  logic [EW-1:0] nl_wa, nl_ra;
  logic [PW-1:0] nl_wd, nl_rd;
  logic          en_we;
  logic [EW-1:0] en_wa, en_ra;
  entry_t        en_wd, en_rd;

  hkit_ram #(.DEPTH(BUCKETS), .WIDTH(PW)) u_bucket (
    .clk(clk), .wr_en(bh_we), .wr_addr(bh_wa), .wr_data(bh_wd),
    .rd_addr(bh_ra), .rd_data(bh_rd));
  hkit_ram #(.DEPTH(ENTRY_COUNT), .WIDTH(PW)) u_link (
    .clk(clk), .wr_en(nl_we), .wr_addr(nl_wa), .wr_data(nl_wd),
    .rd_addr(nl_ra), .rd_data(nl_rd));
  hkit_ram #(.DEPTH(ENTRY_COUNT), .WIDTH($bits(entry_t))) u_entry (
    .clk(clk), .wr_en(en_we), .wr_addr(en_wa), .wr_data(en_wd),
    .rd_addr(en_ra), .rd_data(en_rd));

  logic [3:0] hp_eff;
  logic [BW-1:0] bmask;
  logic key_hit, walk_end;
  cmd_t cmd;

  always_comb begin
    hp_eff = hp_r;
    if (hp_r == 4'd0) hp_eff = 4'd1;
    if ({28'd0, hp_r} > MAX_HASH_POWER) hp_eff = 4'(MAX_HASH_POWER);
    bmask = BW'((64'd1 << hp_eff) - 64'd1);
  end

  assign cmd = cmd_t'(req_r.command);
  assign key_hit = (en_rd.key_high == req_r.key_high) &&
                   (en_rd.key_middle == req_r.key_middle) &&
                   (en_rd.key_low == req_r.key_low);
  assign walk_end = (cur_r >= NIL) || (steps_r >= (EW+1)'(ENTRY_COUNT));

  assign in_stall  = req_v_r;
  assign out_valid = rsp_v_r;
  assign out_data  = rsp_r;

  logic finish;
  rsp_t rsp_nxt;
  logic [PW-1:0] cur_nxt, prev_nxt, free_head_nxt;
  logic [COUNT_W-1:0] free_tot_nxt, used_tot_nxt;
  logic [EW:0] steps_nxt;

  always_comb begin
    state_nxt = state_r;
    finish = 1'b0;
    rsp_nxt = '0;
    cur_nxt = cur_r;
    prev_nxt = prev_r;
    steps_nxt = steps_r;
    free_head_nxt = free_head_r;
    free_tot_nxt = free_tot_r;
    used_tot_nxt = used_tot_r;
    bh_we = 1'b0; bh_wa = bkt_r; bh_wd = NIL; bh_ra = bkt_r;
    nl_we = 1'b0; nl_wa = cur_r[EW-1:0]; nl_wd = NIL; nl_ra = cur_r[EW-1:0];
    en_we = 1'b0; en_wa = free_head_r[EW-1:0]; en_ra = cur_r[EW-1:0];
    en_wd = '{req_r.key_high, req_r.key_middle, req_r.key_low, req_r.segment_id,
              req_r.segment_offset, req_r.expiry_time, req_r.cas_value};
    unique case (state_r)
      S_CLEAR: begin
        if ({1'b0, clr_r} < (CW+1)'(BUCKETS)) begin
          bh_we = 1'b1; bh_wa = clr_r[BW-1:0]; bh_wd = NIL;
        end
        if ({1'b0, clr_r} < (CW+1)'(ENTRY_COUNT)) begin
          nl_we = 1'b1; nl_wa = clr_r[EW-1:0];
          nl_wd = (clr_r == '0) ? NIL : PW'(clr_r - 1'b1);
        end
        if ({1'b0, clr_r} == (CW+1)'(CLR - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (req_v_r && !rsp_v_r) state_nxt = S_HEAD;
      S_HEAD: state_nxt = S_HWAIT;
      S_HWAIT: begin
        cur_nxt = bh_rd; prev_nxt = NIL; steps_nxt = '0;
        state_nxt = S_EREAD;
      end
      S_EREAD: state_nxt = walk_end ? S_CHECK : S_EWAIT;
      S_EWAIT: begin
        if (key_hit) begin
          state_nxt = S_CHECK;
        end else begin
          prev_nxt = cur_r; cur_nxt = nl_rd; steps_nxt = steps_r + 1'b1;
          state_nxt = S_EREAD;
        end
      end
      S_CHECK: begin
        if (!walk_end) begin
          rsp_nxt.found_segment = en_rd.segment;
          rsp_nxt.found_offset  = en_rd.offset;
          rsp_nxt.found_expiry  = en_rd.expiry;
          rsp_nxt.found_cas     = en_rd.cas;
        end
        unique case (cmd) inside
          CMD_INSERT: begin
            if (!walk_end) begin
              rsp_nxt.status = ST_DUPLICATE; finish = 1'b1;
            end else if (free_tot_r == '0 || free_head_r >= NIL) begin
              rsp_nxt.status = ST_POOL_EMPTY; finish = 1'b1;
            end else begin
              en_we = 1'b1;
              nl_ra = free_head_r[EW-1:0];
              state_nxt = S_FREE;
            end
          end
          CMD_REMOVE: begin
            if (walk_end) begin
              rsp_nxt.status = ST_NOT_FOUND; finish = 1'b1;
            end else begin
              state_nxt = S_FIX;
            end
          end
          CMD_LOOKUP, CMD_SPARE: begin
            if (walk_end) rsp_nxt.status = ST_NOT_FOUND;
            finish = 1'b1;
          end
          default: finish = 1'b1;
        endcase
      end
      S_FIX: begin
        if (prev_r < NIL) begin
          nl_we = 1'b1; nl_wa = prev_r[EW-1:0]; nl_wd = nl_rd;
          bh_we = 1'b0;
        end else begin
          bh_we = 1'b1; bh_wd = nl_rd;
        end
        state_nxt = S_FREE;
      end
      S_FREE: begin
        if (cmd == CMD_INSERT) begin
          nl_we = 1'b1; nl_wa = free_head_r[EW-1:0]; nl_wd = bh_rd;
          bh_we = 1'b1; bh_wd = free_head_r;
          free_head_nxt = nl_rd;
          free_tot_nxt = free_tot_r - 1'b1;
          used_tot_nxt = used_tot_r + 1'b1;
        end else begin
          nl_we = 1'b1; nl_wa = cur_r[EW-1:0]; nl_wd = free_head_r;
          free_head_nxt = cur_r;
          free_tot_nxt = free_tot_r + 1'b1;
          if (used_tot_r != '0) used_tot_nxt = used_tot_r - 1'b1;
          rsp_nxt.found_segment = rsp_r.found_segment;
          rsp_nxt.found_offset  = rsp_r.found_offset;
          rsp_nxt.found_expiry  = rsp_r.found_expiry;
          rsp_nxt.found_cas     = rsp_r.found_cas;
        end
        finish = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
    rsp_nxt.free_count = free_tot_nxt;
    rsp_nxt.used_count = used_tot_nxt;
    if (finish) state_nxt = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      hp_r <= 4'd10;
      req_v_r <= 1'b0;
      rsp_v_r <= 1'b0;
      free_head_r <= PW'(ENTRY_COUNT - 1);
      free_tot_r <= COUNT_W'(ENTRY_COUNT);
      used_tot_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_wr_en) hp_r <= cfg_wr_data;
      if (in_valid && !in_stall) begin
        req_v_r <= 1'b1;
      end else if (finish) begin
        req_v_r <= 1'b0;
      end
      if (finish) begin
        rsp_v_r <= 1'b1;
      end else if (!out_stall) begin
        rsp_v_r <= 1'b0;
      end
      free_head_r <= free_head_nxt;
      free_tot_r <= free_tot_nxt;
      used_tot_r <= used_tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) req_r <= in_data;
    if (state_r == S_IDLE) bkt_r <= req_r.hash[BW-1:0] & bmask;
    cur_r <= cur_nxt;
    prev_r <= prev_nxt;
    steps_r <= steps_nxt;
    if (finish || state_r == S_CHECK) rsp_r <= rsp_nxt;
  end

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> req_v_r) else $error("result without request");
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (free_tot_r + used_tot_r) == COUNT_W'(ENTRY_COUNT))
    else $error("entry counts out of balance");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !(in_valid && !in_stall && req_v_r))
    else $error("accept while busy");
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_v_r && out_stall) |=> rsp_v_r) else $error("result dropped");

endmodule

>>> sv/hkit_ram.sv
module hkit_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> verif/tb_hashed_key_index_table.sv
`timescale 1ns / 1ps

module tb_hashed_key_index_table;
  import hkit_pkg::*;

  localparam int POOL_SIZE = 1024;
  localparam int MAX_POWER = 10;
  localparam int LINK_NULL = POOL_SIZE;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 4200;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;
  logic cfg_wr_en;
  logic [3:0] cfg_wr_data;

  hashed_key_index_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  int unsigned bucket_head [POOL_SIZE];
  int unsigned next_link [POOL_SIZE];
  entry_t entries [POOL_SIZE];
  int unsigned free_head;
  int unsigned free_total;
  int unsigned used_total;
  logic [3:0] bucket_bits;

  rsp_t expected_rsps [$];
  req_t known_keys [$];
  int error_count;
  int request_count;
  int rsp_count;
  int idle_cycles;
  int cmd_seen [4];
  int status_seen [4];
  bit long_hold;
  bit stall_random;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned bucket_of(logic [31:0] hash);
    int unsigned p;
    p = 32'(bucket_bits);
    if (p < 1) p = 1;
    if (p > MAX_POWER) p = MAX_POWER;
    return hash & ((32'd1 << p) - 1);
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t rsp;
    int unsigned b, e, prev, p, steps, n;
    b = bucket_of(r.hash);
    e = bucket_head[b];
    p = LINK_NULL;
    prev = LINK_NULL;
    steps = 0;
    rsp = '0;
    while (e < LINK_NULL && steps < POOL_SIZE) begin
      if (entries[e].key_high == r.key_high && entries[e].key_middle == r.key_middle &&
          entries[e].key_low == r.key_low) begin
        prev = p;
        break;
      end
      p = e;
      e = next_link[e];
      steps++;
    end
    if (steps >= POOL_SIZE) e = LINK_NULL;
    if (e < LINK_NULL) begin
      rsp.found_segment = entries[e].segment;
      rsp.found_offset = entries[e].offset;
      rsp.found_expiry = entries[e].expiry;
      rsp.found_cas = entries[e].cas;
    end
    rsp.status = ST_OK;
    case (cmd_t'(r.command))
      CMD_INSERT: begin
        if (e < LINK_NULL) begin
          rsp.status = ST_DUPLICATE;
        end else if (free_total == 0 || free_head >= LINK_NULL) begin
          rsp.status = ST_POOL_EMPTY;
        end else begin
          n = free_head;
          free_head = next_link[n];
          free_total--;
          entries[n] = '{r.key_high, r.key_middle, r.key_low, r.segment_id,
                         r.segment_offset, r.expiry_time, r.cas_value};
          next_link[n] = bucket_head[b];
          bucket_head[b] = n;
          used_total++;
        end
      end
      CMD_REMOVE: begin
        if (e >= LINK_NULL) begin
          rsp.status = ST_NOT_FOUND;
        end else begin
          if (prev < LINK_NULL) next_link[prev] = next_link[e];
          else bucket_head[b] = next_link[e];
          next_link[e] = free_head;
          free_head = e;
          free_total++;
          if (used_total > 0) used_total--;
        end
      end
      default: begin
        if (e >= LINK_NULL) rsp.status = ST_NOT_FOUND;
      end
    endcase
    rsp.free_count = free_total[10:0];
    rsp.used_count = used_total[10:0];
    return rsp;
  endfunction

  task automatic send_request(req_t r);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_rsps.push_back(apply_request(r));
    cmd_seen[r.command]++;
    request_count++;
    if (r.command == CMD_INSERT) known_keys.push_back(r);
    if (known_keys.size() > 300) void'(known_keys.pop_front());
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic write_power(logic [3:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bucket_bits = value;
  endtask

  function automatic req_t random_request();
    req_t r;
    r.command = 2'($urandom_range(0, 3));
    r.hash = $urandom();
    r.key_high = $urandom();
    r.key_middle = {$urandom(), $urandom()};
    r.key_low = {$urandom(), $urandom()};
    r.segment_id = $urandom();
    r.segment_offset = $urandom();
    r.expiry_time = $urandom();
    r.cas_value = {$urandom(), $urandom()};
    return r;
  endfunction

  function automatic req_t known_request(cmd_t cmd);
    req_t r;
    r = random_request();
    if (known_keys.size() != 0) begin
      r = known_keys[$urandom_range(0, known_keys.size() - 1)];
      r.segment_id = $urandom();
      r.cas_value = {$urandom(), $urandom()};
    end
    r.command = cmd;
    return r;
  endfunction

  task automatic test_directed();
    req_t r;
    r = '0;
    r.command = CMD_LOOKUP;
    send_request(r);
    r = '1;
    r.command = CMD_INSERT;
    send_request(r);
    send_request(r);
    r.command = CMD_LOOKUP;
    send_request(r);
    r.command = CMD_SPARE;
    send_request(r);
    r = '0;
    r.command = CMD_INSERT;
    send_request(r);
    r.key_low = 64'd1;
    send_request(r);
    r.key_high = 32'h8000_0000;
    send_request(r);
    r.command = CMD_REMOVE;
    send_request(r);
    send_request(r);
    r = '0;
    r.command = CMD_REMOVE;
    send_request(r);
    r = '1;
    r.command = CMD_REMOVE;
    send_request(r);
    r.command = CMD_LOOKUP;
    send_request(r);
  endtask

  task automatic test_hash_power_sweep();
    req_t r;
    logic [3:0] powers [6] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd11, 4'd10};
    foreach (powers[i]) begin
      write_power(powers[i]);
      repeat (12) begin
        r = ($urandom_range(0, 1) == 0) ? random_request() : known_request(cmd_t'(
            $urandom_range(0, 3)));
        r.hash = $urandom_range(0, 7);
        send_request(r);
      end
    end
  endtask

  task automatic test_random_traffic(int count);
    req_t r;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        r = random_request();
        r.command = CMD_INSERT;
        if ($urandom_range(0, 1) == 0) r.hash = $urandom_range(0, 15);
      end else if (pick < 7) begin
        r = known_request(CMD_LOOKUP);
        if (pick == 6) r.command = CMD_SPARE;
      end else if (pick < 9) begin
        r = known_request(CMD_REMOVE);
      end else begin
        r = random_request();
      end
      send_request(r);
    end
  endtask

  task automatic test_backpressure();
    req_t r;
    long_hold = 1'b1;
    repeat (8) begin
      r = random_request();
      r.command = CMD_INSERT;
      send_request(r);
    end
    long_hold = 1'b0;
    drain();
  endtask

  task automatic test_insert_burst();
    req_t r;
    write_power(4'd10);
    stall_random = 1'b0;
    repeat (40) begin
      r = random_request();
      r.command = CMD_INSERT;
      send_request(r);
    end
    stall_random = 1'b1;
    r = known_request(CMD_INSERT);
    send_request(r);
    test_random_traffic(40);
  endtask

  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 60; hold++) @(posedge clk);
        out_stall <= 1'b0;
        wait (!long_hold);
      end else if (stall_random) begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response %p", out_data);
        error_count++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        rsp_count++;
        status_seen[out_data.status]++;
        if (out_data.status !== exp_rsp.status) begin
          $error("status exp %0d got %0d", exp_rsp.status, out_data.status);
          error_count++;
        end
        if (out_data.found_segment !== exp_rsp.found_segment) begin
          $error("found_segment exp %h got %h", exp_rsp.found_segment,
                 out_data.found_segment);
          error_count++;
        end
        if (out_data.found_offset !== exp_rsp.found_offset) begin
          $error("found_offset exp %h got %h", exp_rsp.found_offset, out_data.found_offset);
          error_count++;
        end
        if (out_data.found_expiry !== exp_rsp.found_expiry) begin
          $error("found_expiry exp %h got %h", exp_rsp.found_expiry, out_data.found_expiry);
          error_count++;
        end
        if (out_data.found_cas !== exp_rsp.found_cas) begin
          $error("found_cas exp %h got %h", exp_rsp.found_cas, out_data.found_cas);
          error_count++;
        end
        if (out_data.free_count !== exp_rsp.free_count) begin
          $error("free_count exp %0d got %0d", exp_rsp.free_count, out_data.free_count);
          error_count++;
        end
        if (out_data.used_count !== exp_rsp.used_count) begin
          $error("used_count exp %0d got %0d", exp_rsp.used_count, out_data.used_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout with %0d responses outstanding", expected_rsps.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 4'd10;
    error_count = 0;
    request_count = 0;
    rsp_count = 0;
    idle_cycles = 0;
    long_hold = 1'b0;
    stall_random = 1'b1;
    for (int i = 0; i < POOL_SIZE; i++) begin
      bucket_head[i] = LINK_NULL;
      next_link[i] = (i == 0) ? LINK_NULL : i - 1;
      entries[i] = '0;
    end
    free_head = POOL_SIZE - 1;
    free_total = POOL_SIZE;
    used_total = 0;
    bucket_bits = 4'd10;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_hash_power_sweep();
    test_backpressure();
    write_power(4'd4);
    test_random_traffic(150);
    test_insert_burst();
    write_power(4'd2);
    test_random_traffic(80);

    drain();
    repeat (100) @(posedge clk);
    $display("requests %0d: lookup %0d insert %0d remove %0d spare %0d", request_count,
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    $display("responses %0d: ok %0d miss %0d full %0d dup %0d", rsp_count,
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0 && expected_rsps.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
